/* rtl/pph_pkg.sv */
// Package for the polyline point hit test: widths, codes, control structs.
// Used by pph_if, pph_mac, pph_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pph_pkg;

  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned RADIUS_W     = 8;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd5;

  localparam int unsigned COORD_W_DEF  = 16;
  localparam int unsigned HALF_W_DEF   = COORD_W_DEF + 1;
  localparam int unsigned MUL_W_DEF    = (COORD_W_DEF + 2 > 2 * RADIUS_W + 1) ?
                                         COORD_W_DEF + 2 : 2 * RADIUS_W + 1;
  localparam int unsigned ACC_W_DEF    = 4 * COORD_W_DEF + 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DRAIN,
    ST_DECIDE,
    ST_PERP,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    STEP_LEN_A,
    STEP_LEN_B,
    STEP_DA_A,
    STEP_DA_B,
    STEP_DB_A,
    STEP_DB_B,
    STEP_DOT_A,
    STEP_DOT_B,
    STEP_CRS_A,
    STEP_CRS_B,
    STEP_RAD,
    STEP_CSQ_A,
    STEP_CSQ_B,
    STEP_CSQ_C,
    STEP_RL_A,
    STEP_RL_B
  } step_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ADD,
    OP_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_HALF,
    SH_HALF1,
    SH_FULL
  } shift_e;

  typedef struct packed {
    logic    en;
    acc_op_e op;
    shift_e  sh;
  } mac_ctrl_t;

  typedef struct packed {
    logic  in_ready;
    step_e step;
    logic  in_step;
    logic  drain;
    logic  decide;
    logic  set_hit;
    logic  commit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic in_first;
    logic last;
    logic perp;
    logic near_end;
    logic near_perp;
    logic out_free;
  } status_t;

  function automatic mac_ctrl_t step_mac(input step_e step);
    mac_ctrl_t m;
    m.en = 1'b1;
    m.op = OP_ADD;
    m.sh = SH_NONE;
    case (step)
      STEP_LEN_A, STEP_DA_A, STEP_DB_A, STEP_DOT_A, STEP_CRS_A,
      STEP_RAD, STEP_CSQ_A, STEP_RL_A: m.op = OP_LOAD;
      STEP_CRS_B: m.op = OP_SUB;
      STEP_CSQ_B: m.sh = SH_HALF1;
      STEP_CSQ_C: m.sh = SH_FULL;
      STEP_RL_B:  m.sh = SH_HALF;
      default:    m.op = OP_ADD;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/pph_if.sv */
// Channel interfaces of the polyline point hit test: vertex input, result
// output and radius write. Depends on pph_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pph_in_if;
  import pph_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  query_x;
  logic signed [FIELD_W-1:0]  query_y;
  logic signed [FIELD_W-1:0]  vertex_x;
  logic signed [FIELD_W-1:0]  vertex_y;
  logic                       first_vertex;
  logic                       last_vertex;
  modport source (output valid, query_x, query_y, vertex_x, vertex_y,
                  first_vertex, last_vertex, input ready);
  modport sink (input valid, query_x, query_y, vertex_x, vertex_y,
                first_vertex, last_vertex, output ready);
endinterface

interface pph_out_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface pph_cfg_if;
  import pph_pkg::*;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] hit_radius;
  modport source (output valid, hit_radius, input ready);
  modport sink (input valid, hit_radius, output ready);
endinterface

`default_nettype wire

/* rtl/pph_mac.sv */
// Shared multiply-accumulate unit: registered product, then shifted
// load, add or subtract into a wide accumulator. Depends on pph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pph_mac #(
  parameter int unsigned MulWidth  = pph_pkg::MUL_W_DEF,
  parameter int unsigned AccWidth  = pph_pkg::ACC_W_DEF,
  parameter int unsigned HalfWidth = pph_pkg::HALF_W_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pph_pkg::mac_ctrl_t         ctrl_i,
  input  logic signed [MulWidth-1:0] a_i,
  input  logic signed [MulWidth-1:0] b_i,
  output logic signed [AccWidth-1:0] acc_o
);
  import pph_pkg::*;

  logic signed [2*MulWidth-1:0] prod_q;
  mac_ctrl_t                    ctrl_q;
  logic signed [AccWidth-1:0]   prod_ext;
  logic signed [AccWidth-1:0]   term;
  logic signed [AccWidth-1:0]   acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  assign prod_ext = AccWidth'(prod_q);

  always_comb begin
    case (ctrl_q.sh)
      SH_NONE:  term = prod_ext;
      SH_HALF:  term = prod_ext <<< HalfWidth;
      SH_HALF1: term = prod_ext <<< (HalfWidth + 1);
      SH_FULL:  term = prod_ext <<< (2 * HalfWidth);
      default:  term = prod_ext;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_q.en) begin
      case (ctrl_q.op)
        OP_LOAD: acc_d = term;
        OP_ADD:  acc_d = acc_q + term;
        OP_SUB:  acc_d = acc_q - term;
        default: acc_d = acc_q;
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/pph_ctrl.sv */
// Sequencer of the hit test: walks the multiply steps of one segment,
// decides the nearest-point case and closes the item. Depends on pph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pph_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pph_pkg::status_t   status_i,
  output pph_pkg::ctrl_t     ctrl_o,
  output pph_pkg::mac_ctrl_t mac_o
);
  import pph_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_LEN_A;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ctrl_o  = '0;
    ctrl_o.step = step_q;
    mac_o   = step_mac(step_q);
    mac_o.en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          if (status_i.in_first) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_STEP;
            step_d  = STEP_LEN_A;
          end
        end
      end
      ST_STEP: begin
        ctrl_o.in_step = 1'b1;
        mac_o.en = 1'b1;
        if (step_q == STEP_RAD || step_q == STEP_RL_B) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      ST_DRAIN: begin
        ctrl_o.drain = 1'b1;
        state_d = (step_q == STEP_RAD) ? ST_DECIDE : ST_PERP;
      end
      ST_DECIDE: begin
        ctrl_o.decide = 1'b1;
        if (status_i.perp) begin
          state_d = ST_STEP;
          step_d  = STEP_CSQ_A;
        end else begin
          ctrl_o.set_hit = status_i.near_end;
          state_d = ST_FIN;
        end
      end
      ST_PERP: begin
        ctrl_o.set_hit = status_i.near_perp;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!status_i.last || status_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/polyline_point_hit_test.sv */
// Top level of the polyline point hit test: channels, held state, operand
// selection and the nearest-point compares. Depends on pph_pkg, pph_if,
// pph_mac and pph_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Vertices stream in one per transfer; each vertex after the first closes a
// segment, and the block reports with the last vertex whether the held query
// point came strictly closer than hit_radius to any segment. One multiplier
// with a registered product and a wide accumulator does all the work, so the
// item rate is set by its step count: a first vertex needs no multiply step, a
// segment walks the steps up to the radius square, and one nearest at the
// perpendicular foot also walks the cross-square and radius-length steps.
// The input is not ready while an item is in work. A result waits in an
// output register and a following item is taken meanwhile. The radius may be
// written at any time the block is idle; its reset value is 5.
module polyline_point_hit_test #(
  parameter int unsigned CoordWidth = pph_pkg::COORD_W_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pph_in_if.sink        in_i,
  pph_out_if.source     out_o,
  pph_cfg_if.sink       cfg_i
);
  import pph_pkg::*;

  localparam int unsigned HalfW = CoordWidth + 1;
  localparam int unsigned MulW  = (CoordWidth + 2 > 2 * RADIUS_W + 1) ?
                                  CoordWidth + 2 : 2 * RADIUS_W + 1;
  localparam int unsigned AccW  = 4 * CoordWidth + 20;

  ctrl_t     ctrl;
  mac_ctrl_t mac_ctrl;
  status_t   status;

  logic in_acc;

  logic [RADIUS_W-1:0]          radius_q;
  logic signed [CoordWidth-1:0] prev_x_q, prev_y_q, qx_q, qy_q, cur_x_q, cur_y_q;
  logic                         hit_q, last_q;
  logic                         out_valid_q, out_hit_q;

  logic [2*HalfW-1:0]         len2_q, da2_q, db2_q, cross_q;
  logic signed [2*HalfW:0]    dot_q;
  logic [4*HalfW-1:0]         csq_q;
  logic [2*RADIUS_W-1:0]      r2_q;

  logic signed [CoordWidth:0] dx, dy, ax, ay, bx, by;
  logic signed [MulW-1:0]     op_a, op_b;
  logic signed [AccW-1:0]     acc, acc_abs;
  logic [AccW-1:0]            acc_u;
  logic                       dot_le0;
  logic [2*HalfW-1:0]         end_d2;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = ctrl.in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.hit = out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        radius_q <= cfg_i.hit_radius;
      end
      if (in_acc) begin
        last_q <= in_i.last_vertex;
        if (in_i.first_vertex) begin
          qx_q <= CoordWidth'($unsigned(in_i.query_x));
          qy_q <= CoordWidth'($unsigned(in_i.query_y));
        end
      end
      if (in_acc && in_i.first_vertex) begin
        hit_q <= 1'b0;
      end else if (ctrl.set_hit) begin
        hit_q <= 1'b1;
      end
      if (ctrl.commit && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.commit) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        if (last_q) begin
          out_hit_q <= hit_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_x_q <= CoordWidth'($unsigned(in_i.vertex_x));
      cur_y_q <= CoordWidth'($unsigned(in_i.vertex_y));
    end
    if (ctrl.in_step && ctrl.step == STEP_DA_B) begin
      len2_q <= acc_u[2*HalfW-1:0];
    end
    if (ctrl.in_step && ctrl.step == STEP_DB_B) begin
      da2_q <= acc_u[2*HalfW-1:0];
    end
    if (ctrl.in_step && ctrl.step == STEP_DOT_B) begin
      db2_q <= acc_u[2*HalfW-1:0];
    end
    if (ctrl.in_step && ctrl.step == STEP_CRS_B) begin
      dot_q <= acc[2*HalfW:0];
    end
    if (ctrl.drain && ctrl.step == STEP_RAD) begin
      cross_q <= acc_abs[2*HalfW-1:0];
    end
    if (ctrl.in_step && ctrl.step == STEP_RL_B) begin
      csq_q <= acc_u[4*HalfW-1:0];
    end
    if (ctrl.decide) begin
      r2_q <= acc_u[2*RADIUS_W-1:0];
    end
  end

  assign dx = (CoordWidth+1)'(cur_x_q) - (CoordWidth+1)'(prev_x_q);
  assign dy = (CoordWidth+1)'(cur_y_q) - (CoordWidth+1)'(prev_y_q);
  assign ax = (CoordWidth+1)'(qx_q) - (CoordWidth+1)'(prev_x_q);
  assign ay = (CoordWidth+1)'(qy_q) - (CoordWidth+1)'(prev_y_q);
  assign bx = (CoordWidth+1)'(qx_q) - (CoordWidth+1)'(cur_x_q);
  assign by = (CoordWidth+1)'(qy_q) - (CoordWidth+1)'(cur_y_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.step)
      STEP_LEN_A: begin op_a = MulW'(dx); op_b = MulW'(dx); end
      STEP_LEN_B: begin op_a = MulW'(dy); op_b = MulW'(dy); end
      STEP_DA_A:  begin op_a = MulW'(ax); op_b = MulW'(ax); end
      STEP_DA_B:  begin op_a = MulW'(ay); op_b = MulW'(ay); end
      STEP_DB_A:  begin op_a = MulW'(bx); op_b = MulW'(bx); end
      STEP_DB_B:  begin op_a = MulW'(by); op_b = MulW'(by); end
      STEP_DOT_A: begin op_a = MulW'(ax); op_b = MulW'(dx); end
      STEP_DOT_B: begin op_a = MulW'(ay); op_b = MulW'(dy); end
      STEP_CRS_A: begin op_a = MulW'(dx); op_b = MulW'(ay); end
      STEP_CRS_B: begin op_a = MulW'(dy); op_b = MulW'(ax); end
      STEP_RAD:   begin op_a = MulW'(radius_q); op_b = MulW'(radius_q); end
      STEP_CSQ_A: begin
        op_a = MulW'(cross_q[HalfW-1:0]);
        op_b = MulW'(cross_q[HalfW-1:0]);
      end
      STEP_CSQ_B: begin
        op_a = MulW'(cross_q[2*HalfW-1:HalfW]);
        op_b = MulW'(cross_q[HalfW-1:0]);
      end
      STEP_CSQ_C: begin
        op_a = MulW'(cross_q[2*HalfW-1:HalfW]);
        op_b = MulW'(cross_q[2*HalfW-1:HalfW]);
      end
      STEP_RL_A:  begin op_a = MulW'(r2_q); op_b = MulW'(len2_q[HalfW-1:0]); end
      STEP_RL_B:  begin
        op_a = MulW'(r2_q);
        op_b = MulW'(len2_q[2*HalfW-1:HalfW]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign acc_u   = acc;
  assign acc_abs = acc[AccW-1] ? -acc : acc;

  assign dot_le0 = dot_q[2*HalfW] || (dot_q == '0);
  assign end_d2  = (len2_q == '0 || dot_le0) ? da2_q : db2_q;

  always_comb begin
    status           = '0;
    status.in_valid  = in_i.valid;
    status.in_first  = in_i.first_vertex;
    status.last      = last_q;
    status.perp      = (len2_q != '0) && !dot_le0 && (dot_q[2*HalfW-1:0] < len2_q);
    status.near_end  = AccW'(end_d2) < acc_u;
    status.near_perp = AccW'(csq_q) < acc_u;
    status.out_free  = !out_valid_q || out_o.ready;
  end

  pph_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .mac_o    (mac_ctrl)
  );

  pph_mac #(
    .MulWidth  (MulW),
    .AccWidth  (AccW),
    .HalfWidth (HalfW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc)
  );

endmodule

`default_nettype wire

/* rtl/pph_checker.sv */
// Port-level checks of the polyline point hit test, and the bind that
// attaches them to the top level. Depends on polyline_point_hit_test.
`timescale 1ns / 1ps
`default_nettype none

module pph_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_first_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_hit_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_single_vertex_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_first_i && in_last_i && !out_valid_i |=> ##1
    (out_valid_i && !out_hit_i))
    else $error("single-vertex polyline did not report a miss");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while idle");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i))
    else $error("stalled result changed");

endmodule

bind polyline_point_hit_test pph_checker u_pph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_first_i  (in_i.first_vertex),
  .in_last_i   (in_i.last_vertex),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hit_i   (out_o.hit)
);

`default_nettype wire

/* sim/polyline_hit_checker.sv */
`timescale 1ns / 1ps
// Result checker of the polyline point hit test: watches the vertex, radius
// and result channels, predicts every hit flag and compares them in order.
// Depends on pph_pkg and pph_if.
module polyline_hit_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pph_in_if    vertex_ch,
  pph_out_if   hit_ch,
  pph_cfg_if   radius_ch,
  output int   pending_o,
  output int   errors_o
);
  import pph_pkg::*;

  typedef logic signed [FIELD_W-1:0] coord_t;

  logic [RADIUS_W-1:0] radius;
  coord_t              anchor_x;
  coord_t              anchor_y;
  coord_t              held_qx;
  coord_t              held_qy;
  logic                line_hit;
  logic                hit_due_q[$];
  int                  due_count = 0;
  int                  mismatch_count = 0;

  assign pending_o = due_count;
  assign errors_o  = mismatch_count;

  // squared distances only: strictly closer than the radius counts
  function automatic logic near_segment(input longint x1, y1, x2, y2, px, py, r2);
    longint      dx, dy, ax, ay, bx, by, len2, dot, crs;
    logic [127:0] crs_sq, bound;
    dx   = x2 - x1;
    dy   = y2 - y1;
    ax   = px - x1;
    ay   = py - y1;
    bx   = px - x2;
    by   = py - y2;
    len2 = dx * dx + dy * dy;
    dot  = ax * dx + ay * dy;
    if (len2 == 0 || dot <= 0) return ax * ax + ay * ay < r2;
    if (dot >= len2) return bx * bx + by * by < r2;
    crs = dx * ay - dy * ax;
    if (crs < 0) crs = -crs;
    crs_sq = 128'(crs) * 128'(crs);
    bound  = 128'(r2) * 128'(len2);
    return crs_sq < bound;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t polyline_hit_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic take_vertex();
    coord_t vx, vy;
    vx = vertex_ch.vertex_x;
    vy = vertex_ch.vertex_y;
    if (vertex_ch.first_vertex) begin
      held_qx  = vertex_ch.query_x;
      held_qy  = vertex_ch.query_y;
      line_hit = 1'b0;
    end else if (near_segment(anchor_x, anchor_y, vx, vy, held_qx, held_qy,
                              longint'(radius) * longint'(radius))) begin
      line_hit = 1'b1;
    end
    anchor_x = vx;
    anchor_y = vy;
    if (vertex_ch.last_vertex) hit_due_q.push_back(line_hit);
  endtask

  task automatic check_hit();
    logic want;
    if (hit_due_q.size() == 0) begin
      flag_mismatch($sformatf("hit=%0b arrived with no result due", hit_ch.hit));
    end else begin
      want = hit_due_q.pop_front();
      if (hit_ch.hit !== want) begin
        flag_mismatch($sformatf("hit=%0b, predicted %0b", hit_ch.hit, want));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius    = RADIUS_RESET;
      anchor_x  = '0;
      anchor_y  = '0;
      held_qx   = '0;
      held_qy   = '0;
      line_hit  = 1'b0;
      hit_due_q.delete();
      due_count <= 0;
    end else begin
      if (radius_ch.valid && radius_ch.ready) radius = radius_ch.hit_radius;
      if (vertex_ch.valid && vertex_ch.ready) take_vertex();
      if (hit_ch.valid && hit_ch.ready) check_hit();
      due_count <= hit_due_q.size();
    end
  end

endmodule

/* sim/polyline_point_hit_test_tb.sv */
`timescale 1ns / 1ps
// Testbench top of the polyline point hit test: clock, reset, bursty vertex
// stimulus, radius writes, a stalling result receiver and the verdict.
// Depends on pph_pkg, pph_if, polyline_point_hit_test and polyline_hit_checker.
module polyline_point_hit_test_tb;
  import pph_pkg::*;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  localparam int PhaseItems   = 250;
  localparam int SettleCycles = 40;
  localparam int LongHold     = 300;

  logic                clk_i;
  logic                rst_ni;
  int                  results_due;
  int                  mismatches;
  int                  receiver_hold = 0;
  int                  burst_left = 0;
  int                  items_sent = 0;
  logic [RADIUS_W-1:0] cur_radius = RADIUS_RESET;

  pph_in_if  vertex_ch ();
  pph_out_if hit_ch ();
  pph_cfg_if radius_ch ();

  polyline_point_hit_test dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vertex_ch),
    .out_o  (hit_ch),
    .cfg_i  (radius_ch)
  );

  polyline_hit_checker hit_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vertex_ch (vertex_ch),
    .hit_ch    (hit_ch),
    .radius_ch (radius_ch),
    .pending_o (results_due),
    .errors_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("polyline_point_hit_test_tb: FAIL");
    $finish;
  end

  // result receiver: stretches of open, coin-flip and sparse ready
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    hit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (receiver_hold > 0) begin
        hit_ch.ready <= 1'b0;
        receiver_hold--;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:  hit_ch.ready <= 1'b1;
          RX_COIN:  hit_ch.ready <= ($urandom_range(0, 1) == 0);
          default:  hit_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic send_vertex(input coord_t qx, qy, vx, vy, input logic is_first, is_last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 30);
      else gap = $urandom_range(1, 4);
      if (gap > 0) begin
        vertex_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    vertex_ch.valid        <= 1'b1;
    vertex_ch.query_x      <= qx;
    vertex_ch.query_y      <= qy;
    vertex_ch.vertex_x     <= vx;
    vertex_ch.vertex_y     <= vy;
    vertex_ch.first_vertex <= is_first;
    vertex_ch.last_vertex  <= is_last;
    @(posedge clk_i);
    while (!vertex_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic await_results();
    vertex_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    radius_ch.valid      <= 1'b1;
    radius_ch.hit_radius <= value;
    @(posedge clk_i);
    while (!radius_ch.ready) @(posedge clk_i);
    radius_ch.valid <= 1'b0;
    cur_radius = value;
  endtask

  function automatic coord_t scatter_near(input coord_t centre, input int spread);
    return coord_t'(int'(centre) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic send_polyline(input bit broken);
    coord_t qx, qy, vx, vy;
    int     n, spread;
    bit     wide, fv, lv;
    n      = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    wide   = ($urandom_range(0, 4) == 0);
    spread = cur_radius + $urandom_range(1, 3 * cur_radius + 8);
    qx     = coord_t'($urandom);
    qy     = coord_t'($urandom);
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        vx = coord_t'($urandom);
        vy = coord_t'($urandom);
      end else begin
        vx = scatter_near(qx, spread);
        vy = scatter_near(qy, spread);
      end
      fv = (i == 0);
      lv = (i == n - 1);
      if (broken) begin
        fv = ($urandom_range(0, 3) == 0);
        lv = ($urandom_range(0, 3) == 0);
      end
      send_vertex(fv ? qx : coord_t'($urandom), fv ? qy : coord_t'($urandom),
                  vx, vy, fv, lv);
    end
  endtask

  task automatic run_random_phase();
    int goal;
    goal = items_sent + PhaseItems;
    while (items_sent < goal) begin
      send_polyline($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 29) == 0) await_results();
    end
  endtask

  task automatic run_directed();
    // no first vertex yet: extend from the reset vertex and query point
    send_vertex(32767, -32768, 3, 0, 0, 0);
    send_vertex(-1, 12345, 100, 100, 0, 1);
    // carry on past the last vertex without a restart
    send_vertex(0, 0, 200, 200, 0, 1);
    // lone vertex
    send_vertex(10, 10, 10, 10, 1, 1);
    // zero-length segment on the radius, then inside it
    send_vertex(0, 0, 3, 4, 1, 0);
    send_vertex(0, 0, 3, 4, 0, 1);
    send_vertex(0, 0, 2, 3, 1, 0);
    send_vertex(0, 0, 2, 3, 0, 1);
    // nearest point at the start, then at the end
    send_vertex(0, 0, -4, 0, 1, 0);
    send_vertex(0, 0, -100, 0, 0, 1);
    send_vertex(0, 0, -100, 3, 1, 0);
    send_vertex(0, 0, -3, 3, 0, 1);
    // perpendicular foot inside the radius, then on it
    send_vertex(0, 0, -1000, 4, 1, 0);
    send_vertex(0, 0, 1000, 5, 0, 1);
    send_vertex(0, 0, -1000, 5, 1, 0);
    send_vertex(0, 0, 1000, 5, 0, 1);
    // full-scale coordinates
    send_vertex(0, 0, -32768, -32768, 1, 0);
    send_vertex(0, 0, 32767, 32767, 0, 1);
    send_vertex(-32768, 32767, 32767, -32768, 1, 0);
    send_vertex(-1, -1, 32767, 32767, 0, 1);
  endtask

  initial begin
    logic [RADIUS_W-1:0] radii [6];
    radii    = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd40, RADIUS_RESET};
    radii[3] = RADIUS_W'($urandom_range(2, 254));
    rst_ni                 <= 1'b0;
    vertex_ch.valid        <= 1'b0;
    vertex_ch.query_x      <= '0;
    vertex_ch.query_y      <= '0;
    vertex_ch.vertex_x     <= '0;
    vertex_ch.vertex_y     <= '0;
    vertex_ch.first_vertex <= 1'b0;
    vertex_ch.last_vertex  <= 1'b0;
    radius_ch.valid        <= 1'b0;
    radius_ch.hit_radius   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    receiver_hold = LongHold;
    run_random_phase();
    for (int p = 0; p < 6; p++) begin
      await_results();
      repeat (SettleCycles) @(posedge clk_i);
      write_radius(radii[p]);
      if (p == 1 || p == 4) receiver_hold = LongHold;
      run_random_phase();
    end
    await_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("polyline_point_hit_test_tb: PASS");
    end else begin
      $display("polyline_point_hit_test_tb: FAIL");
    end
    $finish;
  end

endmodule
